>>> hdl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
// Used by brf_ctrl, brf_dp and byte_ring_fifo_top; no dependencies.
`default_nettype none

package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 8;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ACT_W     = 3;
    localparam int WORD_W    = 64;
    localparam int BYTE_W    = 8;
    localparam int LANE_W    = $clog2(WORD_W / BYTE_W);

    // s_tdata: count, data, match_byte; m_tdata: read_data, found_position, fill_level
    localparam int S_TDATA_W = ((CNT_W + WORD_W + BYTE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + CNT_W + CNT_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POLL  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIND  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted request
        logic start;    // rewind the byte walk, clear the gathered results
        logic walk_wr;  // write one byte per cycle at the tail
        logic walk_rd;  // read one byte per cycle from the head
        logic commit;   // update pointers and load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             legal;
        logic             idx_end;
        logic             rd_vld;
        logic             hit;
        logic             out_busy;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/brf_ctrl.sv
// Sequencer of the byte ring FIFO: accepts a request, runs the byte walk, commits.
// Depends on brf_pkg.
`default_nettype none

module brf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire brf_pkg::sts_t sts,
    output brf_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.start = 1'b1;
                if (!sts.legal) begin
                    state_next = ST_DONE;
                end else if (sts.act == brf_pkg::ACT_PUSH) begin
                    state_next = ST_WRITE;
                end else if (sts.act inside {brf_pkg::ACT_POLL, brf_pkg::ACT_PEEK}) begin
                    state_next = ST_READ;
                end else if (sts.act == brf_pkg::ACT_FIND) begin
                    state_next = ST_SEARCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                cmd.walk_wr = 1'b1;
                if (sts.idx_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.walk_rd = 1'b1;
                if (sts.idx_end && !sts.rd_vld) begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH: begin
                cmd.walk_rd = 1'b1;
                // stop at the first match or once the last byte has come back
                if (sts.hit || (sts.idx_end && !sts.rd_vld)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_decide_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> $past(s_tvalid && s_tready))
        else $error("decide without an accepted request");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !sts.out_busy) |=> (state_reg == ST_IDLE))
        else $error("done state did not commit");

    a_walk_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.walk_wr && cmd.walk_rd) && !(cmd.commit && cmd.load))
        else $error("conflicting commands");

endmodule

`default_nettype wire

>>> hdl/brf_dp.sv
// Datapath of the byte ring FIFO: pointers, request registers, byte walk,
// byte store and result register. Depends on brf_pkg and brf_ram.
`default_nettype none

module brf_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [brf_pkg::ACT_W-1:0]           s_tuser,
    input  wire logic [brf_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [brf_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic [0:0]                               m_tuser,
    input  wire brf_pkg::cmd_t                       cmd,
    output brf_pkg::sts_t                            sts
);

    localparam int CW = brf_pkg::CNT_W;
    localparam int AW = brf_pkg::ADDR_W;
    localparam int WW = brf_pkg::WORD_W;
    localparam int BW = brf_pkg::BYTE_W;
    localparam int LW = brf_pkg::LANE_W;

    // ring state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] stored_reg, stored_next;

    // captured request
    logic [brf_pkg::ACT_W-1:0] act_reg;
    logic [CW-1:0]             cnt_reg;
    logic [WW-1:0]             data_reg;
    logic [BW-1:0]             match_reg;

    // byte walk
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          rd_vld_reg;
    logic [WW-1:0] rdata_reg;
    logic [CW-1:0] found_reg;
    logic          found_vld_reg;

    // result register
    logic                    m_tvalid_reg;
    logic [brf_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                    m_ok_reg;

    logic          legal;
    logic [CW-1:0] limit;
    logic          idx_end;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [BW-1:0] mem_wdata;
    logic [BW-1:0] mem_rdata;
    logic          hit;
    logic [CW-1:0] free_cnt;
    logic          burst_ok;

    always_comb begin
        free_cnt = CW'(brf_pkg::DEPTH) - stored_reg;
        burst_ok = (cnt_reg <= CW'(brf_pkg::MAX_BURST));
        case (act_reg)
            brf_pkg::ACT_PUSH:  legal = burst_ok && (cnt_reg <= free_cnt);
            brf_pkg::ACT_POLL,
            brf_pkg::ACT_PEEK:  legal = burst_ok && (cnt_reg <= stored_reg);
            brf_pkg::ACT_FLUSH: legal = (cnt_reg <= stored_reg);
            brf_pkg::ACT_FIND,
            brf_pkg::ACT_CLEAR: legal = 1'b1;
            default:            legal = 1'b0;
        endcase
    end

    assign limit   = (act_reg == brf_pkg::ACT_FIND) ? stored_reg : cnt_reg;
    assign idx_end = (idx_reg == limit);

    assign mem_we    = cmd.walk_wr && !idx_end;
    assign mem_re    = cmd.walk_rd && !idx_end;
    assign mem_waddr = tail_reg + idx_reg[AW-1:0];
    assign mem_raddr = head_reg + idx_reg[AW-1:0];
    assign mem_wdata = data_reg[BW*idx_reg[LW-1:0] +: BW];

    assign hit = rd_vld_reg && !found_vld_reg && (act_reg == brf_pkg::ACT_FIND) &&
                 (mem_rdata == match_reg);

    brf_ram #(
        .WIDTH (BW),
        .DEPTH (brf_pkg::DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // pointer update on commit
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        stored_next = stored_reg;
        if (legal) begin
            case (act_reg)
                brf_pkg::ACT_PUSH: begin
                    tail_next   = tail_reg + cnt_reg[AW-1:0];
                    stored_next = stored_reg + cnt_reg;
                end
                brf_pkg::ACT_POLL,
                brf_pkg::ACT_FLUSH: begin
                    head_next   = head_reg + cnt_reg[AW-1:0];
                    stored_next = stored_reg - cnt_reg;
                end
                brf_pkg::ACT_CLEAR: begin
                    head_next   = '0;
                    tail_next   = '0;
                    stored_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            stored_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= mem_re;
            if (cmd.commit) begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                stored_reg   <= stored_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= s_tuser;
            cnt_reg   <= s_tdata[CW-1:0];
            data_reg  <= s_tdata[CW +: WW];
            match_reg <= s_tdata[CW+WW +: BW];
        end
        if (cmd.start) begin
            idx_reg       <= '0;
            rdata_reg     <= '0;
            found_reg     <= '0;
            found_vld_reg <= 1'b0;
        end else begin
            if (mem_we || mem_re) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (rd_vld_reg && act_reg != brf_pkg::ACT_FIND) begin
                rdata_reg[BW*rd_idx_reg[LW-1:0] +: BW] <= mem_rdata;
            end
            if (hit) begin
                found_reg     <= rd_idx_reg + CW'(1);
                found_vld_reg <= 1'b1;
            end
        end
        rd_idx_reg <= idx_reg;
        if (cmd.commit) begin
            m_ok_reg    <= legal;
            m_tdata_reg <= brf_pkg::M_TDATA_W'({
                stored_next,
                (act_reg == brf_pkg::ACT_FIND) ? found_reg : CW'(0),
                (legal && (act_reg == brf_pkg::ACT_POLL || act_reg == brf_pkg::ACT_PEEK))
                    ? rdata_reg : WW'(0)
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_ok_reg;

    assign sts.act      = act_reg;
    assign sts.legal    = legal;
    assign sts.idx_end  = idx_end;
    assign sts.rd_vld   = rd_vld_reg;
    assign sts.hit      = hit;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= CW'(brf_pkg::DEPTH))
        else $error("fill level above depth");

    a_write_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (idx_reg < CW'(brf_pkg::MAX_BURST)) && (act_reg == brf_pkg::ACT_PUSH))
        else $error("store write outside a push burst");

    a_read_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> (idx_reg < stored_reg))
        else $error("store read past the fill level");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid_reg && !m_tready) ##1 m_tvalid_reg)
        else $error("result overwritten or not shown");

endmodule

`default_nettype wire

>>> hdl/byte_ring_fifo_top.sv
// Byte ring FIFO: a request is accepted in IDLE, then passes DECIDE, a byte walk
// through the byte store, and a commit in DONE; flush, clear and refused requests
// skip the walk, and find stops at the first match or after all stored bytes. A
// request is taken once the previous one has committed, while its result may still
// wait in the output register. The byte walk makes one store access a cycle.
// aresetn (synchronous) empties the ring.
`default_nettype none

module byte_ring_fifo_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // count[10:0], data[74:11], match_byte[82:75], zero fill
    input  wire logic [brf_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[2:0]
    input  wire logic [brf_pkg::ACT_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_data[63:0], found_position[74:64], fill_level[85:75], zero fill
    output logic [brf_pkg::M_TDATA_W-1:0]          m_tdata,
    // ok[0]
    output logic [0:0]                             m_tuser
);

    brf_pkg::cmd_t cmd;
    brf_pkg::sts_t sts;

    brf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire
